>>> hdl/skcm_pkg.sv
// shared types, widths and constants of the sky texture coordinate mapper
// no dependencies; used by every module of the block

package skcm_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = 5;
    localparam int GUARD        = 24;

    localparam int R_W    = 30;   // ray components
    localparam int XY_W   = 57;   // cordic x / y
    localparam int Z_W    = 17;   // cordic angle, signed q.13
    localparam int ANG_W  = 16;   // wrapped angle
    localparam int ROW_W  = 11;
    localparam int COL_W  = 12;
    localparam int CAM_W  = 15;
    localparam int SW_W   = 12;
    localparam int HALF_W = 11;
    localparam int RS_W   = 17;   // sky_repeat * sky_width
    localparam int BAND_W = 29;
    localparam int MH_W   = 32;   // floor(2^31 / half)
    localparam int C2_W   = 30;

    // angle constants at 13 fraction bits, rounded to nearest
    localparam logic [15:0]        TWO_PI       = 16'd51472;
    localparam logic signed [Z_W-1:0] HALF_PI   = 17'sd12868;
    localparam logic [16:0]        TWO_PI_RECIP = 17'd83442;   // floor(2^32 / TWO_PI)

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_W  = 3'd0;
    localparam logic [2:0] REG_SCREEN_H  = 3'd1;
    localparam logic [2:0] REG_SKY_W     = 3'd2;
    localparam logic [2:0] REG_SKY_H     = 3'd3;
    localparam logic [2:0] REG_SKY_REP   = 3'd4;
    localparam logic [2:0] REG_FOV       = 3'd5;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic [ROW_W-1:0]       row;
    } cord_t;

    // values derived from the configuration registers
    typedef struct packed {
        logic                   busy;
        logic [SW_W-1:0]        sw;
        logic [HALF_W-1:0]      half;
        logic [RS_W-1:0]        rs;
        logic [BAND_W-1:0]      bq;
        logic [HALF_W-1:0]      br;
        logic [MH_W-1:0]        mh;
        logic signed [C2_W-1:0] c2;
    } cfg_drv_t;

    // atan(2^-i) at 13 fraction bits
    function automatic logic signed [Z_W-1:0] atan_q(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:    r = 17'sd6434;
            5'd1:    r = 17'sd3798;
            5'd2:    r = 17'sd2007;
            5'd3:    r = 17'sd1019;
            5'd4:    r = 17'sd511;
            5'd5:    r = 17'sd256;
            5'd6:    r = 17'sd128;
            5'd7:    r = 17'sd64;
            5'd8:    r = 17'sd32;
            5'd9:    r = 17'sd16;
            5'd10:   r = 17'sd8;
            5'd11:   r = 17'sd4;
            5'd12:   r = 17'sd2;
            5'd13:   r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/skcm_cordic_cell.sv
// one vectoring micro-rotation of the heading cordic, with its stage register
// depends on skcm_pkg

module skcm_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [skcm_pkg::STEP_W-1:0]   step,
    input  logic                          load,
    input  logic                          in_valid,
    input  skcm_pkg::cord_t               in_data,
    output logic                          out_valid,
    output skcm_pkg::cord_t               out_data
);
    import skcm_pkg::*;

    logic                   valid_reg;
    cord_t                  data_reg;
    cord_t                  data_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  a;

    // arithmetic shift is the floor shift
    always_comb
    begin
        xs = in_data.x >>> step;
        ys = in_data.y >>> step;
        a  = atan_q(step);
        data_next = in_data;
        if (in_data.y >= 0)
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + a;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/skcm_cfg.sv
// configuration registers and the sequencer that derives the per-frame constants
// with a shared bit-serial divider; depends on skcm_pkg

module skcm_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output skcm_pkg::cfg_drv_t    drv
);
    import skcm_pkg::*;

    localparam int NUM_W     = 44;
    localparam int DEN_W     = 28;
    localparam int DIV_STEPS = 44;
    localparam int CNT_W     = 6;

    typedef enum logic [2:0] {
        ST_M1, ST_M2, ST_M3, ST_D1, ST_D2, ST_D3, ST_FIN, ST_DONE
    } seq_state_t;

    logic [11:0]            screen_w_reg;
    logic [11:0]            screen_h_reg;
    logic [11:0]            sky_w_reg;
    logic [11:0]            sky_h_reg;
    logic [4:0]             sky_rep_reg;
    logic [15:0]            fov_reg;

    seq_state_t             state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [32:0]            prod_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [BAND_W-1:0]      band_reg;
    logic [BAND_W-1:0]      bq_reg;
    logic [HALF_W-1:0]      br_reg;
    logic [MH_W-1:0]        mh_reg;
    logic signed [C2_W-1:0] c2_reg;
    logic [RS_W-1:0]        rs_reg;

    logic [SW_W-1:0]        sw_eff;
    logic [HALF_W-1:0]      half_eff;
    logic [DEN_W:0]         rem_sh;
    logic                   ge;
    logic [DEN_W-1:0]       rem_next;
    logic [NUM_W-1:0]       num_next;
    logic                   last;
    logic signed [30:0]     diff;
    logic signed [30:0]     diff_adj;

    assign sw_eff   = (screen_w_reg == '0) ? SW_W'(1) : screen_w_reg;
    assign half_eff = (screen_h_reg[11:1] == '0) ? HALF_W'(1) : screen_h_reg[11:1];

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], ge};
        last     = cnt_reg == CNT_W'(DIV_STEPS - 1);
        diff     = $signed({19'd0, sky_h_reg}) - $signed({2'd0, band_reg});
        diff_adj = diff + $signed({30'd0, diff[30]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= 12'd640;
            screen_h_reg <= 12'd480;
            sky_w_reg    <= 12'd1024;
            sky_h_reg    <= 12'd512;
            sky_rep_reg  <= 5'd1;
            fov_reg      <= 16'd9562;
            state_reg    <= ST_M1;
            cnt_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_W: screen_w_reg <= cfg_data[11:0];
                REG_SCREEN_H: screen_h_reg <= cfg_data[11:0];
                REG_SKY_W:    sky_w_reg    <= cfg_data[11:0];
                REG_SKY_H:    sky_h_reg    <= cfg_data[11:0];
                REG_SKY_REP:  sky_rep_reg  <= cfg_data[4:0];
                REG_FOV:      fov_reg      <= cfg_data;
                default:      ;
            endcase
            state_reg <= ST_M1;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_M3;
                ST_M3:
                begin
                    state_reg <= ST_D1;
                    cnt_reg   <= '0;
                end
                ST_D1, ST_D2, ST_D3:
                begin
                    cnt_reg <= last ? '0 : cnt_reg + CNT_W'(1);
                    if (last)
                        state_reg <= (state_reg == ST_D1) ? ST_D2 :
                                     (state_reg == ST_D2) ? ST_D3 : ST_FIN;
                end
                ST_FIN:  state_reg <= ST_DONE;
                ST_DONE: state_reg <= ST_DONE;
                default: state_reg <= ST_M1;
            endcase
        end
    end

    // datapath of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_M1: prod_reg <= 33'(sky_rep_reg * fov_reg);
            ST_M2: prod_reg <= 33'(prod_reg[20:0] * sky_w_reg);
            ST_M3:
            begin
                num_reg <= NUM_W'(prod_reg * half_eff);
                den_reg <= DEN_W'(TWO_PI * sw_eff);
                rem_reg <= '0;
            end
            ST_D1:
            begin
                if (last)
                begin
                    band_reg <= num_next[BAND_W-1:0];
                    num_reg  <= NUM_W'(num_next[BAND_W-1:0]);
                    den_reg  <= DEN_W'(half_eff);
                    rem_reg  <= '0;
                end
                else
                begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                end
            end
            ST_D2:
            begin
                if (last)
                begin
                    bq_reg  <= num_next[BAND_W-1:0];
                    br_reg  <= rem_next[HALF_W-1:0];
                    num_reg <= NUM_W'(1) << 31;
                    den_reg <= DEN_W'(half_eff);
                    rem_reg <= '0;
                end
                else
                begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                end
            end
            ST_D3:
            begin
                if (last)
                    mh_reg <= num_next[MH_W-1:0];
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
            ST_FIN:
            begin
                c2_reg <= C2_W'(diff_adj >>> 1);
                rs_reg <= RS_W'(sky_rep_reg * sky_w_reg);
            end
            default: ;
        endcase
    end

    assign drv.busy = state_reg != ST_DONE;
    assign drv.sw   = sw_eff;
    assign drv.half = half_eff;
    assign drv.rs   = rs_reg;
    assign drv.bq   = bq_reg;
    assign drv.br   = br_reg;
    assign drv.mh   = mh_reg;
    assign drv.c2   = c2_reg;

endmodule

>>> hdl/sky_texture_coord_mapper_core.sv
// top level of the sky texture coordinate mapper: ray build, cordic cell chain,
// texture scaling; depends on skcm_pkg, skcm_cordic_cell and skcm_cfg

// One item per clock while s_tready is high: each item holds the player direction, the
// camera plane and a pixel (column, row); each yields one result item with the sky
// texel (tex_x, tex_y). Two stages build the ray, one pre-rotates it by a quarter turn,
// fourteen cordic cells resolve the heading, four stages scale it, and an output
// register holds the result. Every stage holds its item while the stage ahead is full
// and cannot move on, so the block keeps taking items while a result waits as long as
// an empty slot remains. After reset and after every configuration write the block
// derives its frame constants with a shared one-bit-per-cycle divider: s_tready stays
// low through three multiplies, three divisions of 44 quotient bits and one finishing step.
// Configuration writes are always taken (cfg_ready is tied high) and must be made only
// while no items are in flight. tex_x saturates at 65535, tex_y at the 16-bit limits.

module sky_texture_coord_mapper_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dir_x[15:0] dir_y[31:16] plane_x[47:32] plane_y[63:48] column[75:64] row[86:76]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tex_x[15:0] tex_y[31:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import skcm_pkg::*;

    // stage positions along the pipeline
    localparam int ST_CELL0 = 3;
    localparam int ST_T1    = ST_CELL0 + CORDIC_STEPS;
    localparam int ST_T2    = ST_T1 + 1;
    localparam int ST_T3    = ST_T1 + 2;
    localparam int ST_T4    = ST_T1 + 3;
    localparam int ST_OUT   = ST_T1 + 4;
    localparam int NST      = ST_OUT + 1;
    localparam logic [17:0] REMX_LIMIT = 18'(TWO_PI) * 18'd3;

    cfg_drv_t drv;

    // input fields
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;

    assign dir_x   = $signed(s_tdata[15:0]);
    assign dir_y   = $signed(s_tdata[31:16]);
    assign plane_x = $signed(s_tdata[47:32]);
    assign plane_y = $signed(s_tdata[63:48]);
    assign column  = s_tdata[75:64];
    assign row     = s_tdata[86:76];

    // stage enables: a stage loads when it is empty or the stage ahead moves
    logic [NST-1:0] v;
    logic [NST-1:0] en;
    logic           accept;

    always_comb
    begin
        en[NST-1] = ~v[NST-1] | m_tready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = ~v[k] | en[k+1];
    end

    assign s_tready  = en[0] & ~drv.busy;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    skcm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .drv       (drv)
    );

    // ---------------- ray build ----------------
    logic signed [CAM_W-1:0] cam;
    logic signed [R_W-1:0]   sw_s;
    logic signed [R_W-1:0]   cam_s;

    assign cam   = $signed({2'b00, column, 1'b0}) - $signed({3'b000, drv.sw});
    assign sw_s  = $signed(R_W'(drv.sw));
    assign cam_s = R_W'(cam);

    logic                  f1_v_reg, f2_v_reg, f3_v_reg;
    logic signed [R_W-1:0] f1_pdx_reg, f1_ppx_reg, f1_pdy_reg, f1_ppy_reg;
    logic [ROW_W-1:0]      f1_row_reg, f2_row_reg;
    logic signed [R_W-1:0] f2_rx_reg, f2_ry_reg;
    cord_t                 f3_reg;
    cord_t                 f3_next;
    logic signed [XY_W-1:0] gx;
    logic signed [XY_W-1:0] gy;

    // quarter-turn pre-rotation so the cordic starts in the right half plane
    always_comb
    begin
        gx = XY_W'(f2_ry_reg) <<< GUARD;
        gy = XY_W'(f2_rx_reg) <<< GUARD;
        f3_next.zero = (f2_rx_reg == '0) && (f2_ry_reg == '0);
        f3_next.row  = f2_row_reg;
        f3_next.x    = gx;
        f3_next.y    = gy;
        f3_next.z    = '0;
        if (gx < 0)
        begin
            if (gy >= 0)
            begin
                f3_next.x = gy;
                f3_next.y = -gx;
                f3_next.z = HALF_PI;
            end
            else
            begin
                f3_next.x = -gy;
                f3_next.y = gx;
                f3_next.z = -HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f1_pdx_reg <= R_W'(dir_x) * sw_s;
            f1_ppx_reg <= R_W'(plane_x) * cam_s;
            f1_pdy_reg <= R_W'(dir_y) * sw_s;
            f1_ppy_reg <= R_W'(plane_y) * cam_s;
            f1_row_reg <= row;
        end
        if (en[1])
        begin
            f2_rx_reg  <= f1_pdx_reg + f1_ppx_reg;
            f2_ry_reg  <= f1_pdy_reg + f1_ppy_reg;
            f2_row_reg <= f1_row_reg;
        end
        if (en[2])
            f3_reg <= f3_next;
    end

    // ---------------- cordic cell chain ----------------
    logic  cv [CORDIC_STEPS+1];
    cord_t cd [CORDIC_STEPS+1];

    assign cv[0] = f3_v_reg;
    assign cd[0] = f3_reg;

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cell
        skcm_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(j)),
            .load      (en[ST_CELL0+j]),
            .in_valid  (cv[j]),
            .in_data   (cd[j]),
            .out_valid (cv[j+1]),
            .out_data  (cd[j+1])
        );
        assign v[ST_CELL0+j] = cv[j+1];
    end

    // ---------------- texture scaling ----------------
    logic                    t1_v_reg, t2_v_reg, t3_v_reg, t4_v_reg, out_v_reg;
    logic [ANG_W-1:0]        t1_ang_reg;
    logic [39:0]             t1_pb_reg, t2_pb_reg, t3_pb_reg, t4_pb_reg;
    logic [21:0]             t1_n_reg, t2_n_reg, t3_n_reg;
    logic [32:0]             t2_num_reg, t3_num_reg;
    logic [53:0]             t2_t_reg;
    logic [49:0]             t3_t2_reg;
    logic [21:0]             t3_q0h_reg, t4_q0h_reg;
    logic [17:0]             t4_q0x_reg;
    logic [17:0]             t4_remx_reg;
    logic [11:0]             t4_remh_reg;
    logic [15:0]             tex_x_reg;
    logic signed [15:0]      tex_y_reg;

    logic signed [Z_W-1:0]   nz;
    logic [ANG_W-1:0]        ang;
    logic [17:0]             q0x;
    logic [33:0]             remx;
    logic [22:0]             remh;
    logic [18:0]             qx;
    logic signed [41:0]      tyf;

    // heading angle wrapped into [0, 2pi)
    always_comb
    begin
        nz = -cd[CORDIC_STEPS].z;
        if (cd[CORDIC_STEPS].zero)
            ang = '0;
        else if (nz < 0)
            ang = ANG_W'(nz + $signed({1'b0, TWO_PI}));
        else
            ang = ANG_W'(nz);
        q0x  = t3_t2_reg[49:32];
        remx = 34'(t3_num_reg) - 34'(q0x) * 34'(TWO_PI);
        remh = 23'(t3_n_reg) - 23'(t3_q0h_reg) * 23'(drv.half);
        // the reciprocal estimates fall short by at most two (tex_x) and one (tex_y)
        qx = 19'(t4_q0x_reg)
           + ((t4_remx_reg >= 18'(TWO_PI)) ? 19'd1 : 19'd0)
           + ((t4_remx_reg >= 18'(TWO_PI) * 18'd2) ? 19'd1 : 19'd0);
        tyf = $signed({2'b00, t4_pb_reg}) + $signed({20'd0, t4_q0h_reg})
            + ((t4_remh_reg >= 12'(drv.half)) ? 42'sd1 : 42'sd0)
            + 42'(drv.c2);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_T1])
        begin
            t1_ang_reg <= ang;
            t1_pb_reg  <= 40'(cd[CORDIC_STEPS].row) * 40'(drv.bq);
            t1_n_reg   <= 22'(cd[CORDIC_STEPS].row) * 22'(drv.br);
        end
        if (en[ST_T2])
        begin
            t2_num_reg <= 33'(t1_ang_reg) * 33'(drv.rs);
            t2_t_reg   <= 54'(t1_n_reg) * 54'(drv.mh);
            t2_pb_reg  <= t1_pb_reg;
            t2_n_reg   <= t1_n_reg;
        end
        if (en[ST_T3])
        begin
            t3_t2_reg  <= 50'(t2_num_reg) * 50'(TWO_PI_RECIP);
            t3_num_reg <= t2_num_reg;
            t3_q0h_reg <= t2_t_reg[52:31];
            t3_pb_reg  <= t2_pb_reg;
            t3_n_reg   <= t2_n_reg;
        end
        if (en[ST_T4])
        begin
            t4_q0x_reg  <= q0x;
            t4_remx_reg <= remx[17:0];
            t4_remh_reg <= remh[11:0];
            t4_q0h_reg  <= t3_q0h_reg;
            t4_pb_reg   <= t3_pb_reg;
        end
        if (en[ST_OUT])
        begin
            tex_x_reg <= (qx > 19'd65535) ? 16'hFFFF : qx[15:0];
            if (tyf > 42'sd32767)
                tex_y_reg <= 16'sh7FFF;
            else if (tyf < -42'sd32768)
                tex_y_reg <= 16'sh8000;
            else
                tex_y_reg <= tyf[15:0];
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            f3_v_reg  <= 1'b0;
            t1_v_reg  <= 1'b0;
            t2_v_reg  <= 1'b0;
            t3_v_reg  <= 1'b0;
            t4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en[0])      f1_v_reg  <= accept;
            if (en[1])      f2_v_reg  <= f1_v_reg;
            if (en[2])      f3_v_reg  <= f2_v_reg;
            if (en[ST_T1])  t1_v_reg  <= cv[CORDIC_STEPS];
            if (en[ST_T2])  t2_v_reg  <= t1_v_reg;
            if (en[ST_T3])  t3_v_reg  <= t2_v_reg;
            if (en[ST_T4])  t4_v_reg  <= t3_v_reg;
            if (en[ST_OUT]) out_v_reg <= t4_v_reg;
        end
    end

    assign v[0]      = f1_v_reg;
    assign v[1]      = f2_v_reg;
    assign v[2]      = f3_v_reg;
    assign v[ST_T1]  = t1_v_reg;
    assign v[ST_T2]  = t2_v_reg;
    assign v[ST_T3]  = t3_v_reg;
    assign v[ST_T4]  = t4_v_reg;
    assign v[ST_OUT] = out_v_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {tex_y_reg, tex_x_reg};

`ifndef SYNTHESIS
    // a configuration write always restarts the constant derivation
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> drv.busy)
        else $error("constant derivation not restarted after configuration write");

    // the tex_x reciprocal estimate is short by at most two
    a_remx: assert property (@(posedge clk) disable iff (!rst_n)
        t4_v_reg |-> t4_remx_reg < REMX_LIMIT)
        else $error("tex_x remainder out of correction range");

    // the tex_y reciprocal estimate is short by at most one
    a_remh: assert property (@(posedge clk) disable iff (!rst_n)
        t4_v_reg |-> t4_remh_reg < {drv.half, 1'b0})
        else $error("tex_y remainder out of correction range");
`endif

endmodule
